### hw/rtl/spike_bin_counter_macros.svh
// ---------------------------------------------------------------------------
// spike_bin_counter assertion macros
// shared assertion forms for the bin counter rtl
// ---------------------------------------------------------------------------
`ifndef SPIKE_BIN_COUNTER_MACROS_SVH
`define SPIKE_BIN_COUNTER_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define SBC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// property that must hold in the cycle after its trigger
`define SBC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sbc_pkg.sv
// ---------------------------------------------------------------------------
// sbc_pkg
// types, codes and constants shared by the spike bin counter modules
// ---------------------------------------------------------------------------
package sbc_pkg;

  localparam int MAX_BINS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 32;

  localparam int CHAN_W   = 5;
  localparam int UNITS_W  = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CHAN_W-1:0]  CHANNELS_RST = 5'd16;
  localparam logic [UNITS_W-1:0] UNITS_RST    = 3'd4;

  localparam int BYTE_MAX = 255;

  // width of the bin number computed from an event
  localparam int BIN_CALC_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNELS = 1'd0,
    CFG_UNITS    = 1'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FUNC_ADD       = 2'd0,
    FUNC_CLEAR     = 2'd1,
    FUNC_DUMP      = 2'd2,
    FUNC_DUMP_BYTE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CHAN_LOW  = 3'd1,
    ST_CHAN_HIGH = 3'd2,
    ST_UNIT_HIGH = 3'd3,
    ST_ROOM      = 3'd4
  } status_t;

  typedef struct packed {
    func_t      func;
    logic [7:0] channel;
    logic [3:0] unit;
    logic [6:0] room;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  bin_index;
    logic [31:0] count;
    logic        last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_ADD,
    S_DUMP,
    S_RESP
  } state_t;

endpackage

### hw/rtl/sbc_mem.sv
// ---------------------------------------------------------------------------
// sbc_mem
// bin count store, one write and one registered read port
// ---------------------------------------------------------------------------
module sbc_mem import sbc_pkg::*; #(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int ADDR_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1
) (
  input  logic                  clk,
  input  logic                  re,
  input  logic [ADDR_W-1:0]     raddr,
  output logic [COUNT_BITS-1:0] rdata,
  input  logic                  we,
  input  logic [ADDR_W-1:0]     waddr,
  input  logic [COUNT_BITS-1:0] wdata
);

  logic [COUNT_BITS-1:0] mem [MAX_BINS];

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

### hw/rtl/sbc_rsp_reg.sv
// ---------------------------------------------------------------------------
// sbc_rsp_reg
// output register for result transfers
// ---------------------------------------------------------------------------
module sbc_rsp_reg import sbc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsp_t push_data,
  output logic ready,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  assign ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ready) begin
      rsp_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      rsp <= push_data;
    end
  end

endmodule

### hw/rtl/sbc_ctrl.sv
// ---------------------------------------------------------------------------
// sbc_ctrl
// command decode, read-modify-write sequencing, dump walk and clear sweep
// ---------------------------------------------------------------------------
`include "spike_bin_counter_macros.svh"

module sbc_ctrl import sbc_pkg::*; #(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  localparam int ADDR_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1,
  localparam int CNT_W     = $clog2(MAX_BINS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  mem_re,
  output logic [ADDR_W-1:0]     mem_raddr,
  input  logic [COUNT_BITS-1:0] mem_rdata,
  output logic                  mem_we,
  output logic [ADDR_W-1:0]     mem_waddr,
  output logic [COUNT_BITS-1:0] mem_wdata,
  input  logic                  res_ready,
  output logic                  res_push,
  output rsp_t                  res
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] BYTE_CAP  = COUNT_BITS'(BYTE_MAX);
  localparam logic [CNT_W-1:0]      LAST_BIN  = CNT_W'(MAX_BINS - 1);

  state_t state, state_next;

  logic [CHAN_W-1:0]  channels_in_use;
  logic [UNITS_W-1:0] units_per_channel;

  logic [CNT_W-1:0]  idx, idx_next;
  logic              clr_reply, clr_reply_next;
  status_t           op_status, op_status_next;
  logic [ADDR_W-1:0] op_addr, op_addr_next;
  logic              op_byte, op_byte_next;

  logic                  accept;
  logic                  ch_high;
  logic                  unit_high;
  logic                  bin_high;
  logic [BIN_CALC_W-1:0] bin_calc;
  status_t               add_status;
  logic [7:0]            total_raw;
  logic [CNT_W-1:0]      total;
  logic                  room_short;
  logic                  dump_last;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] count_dump;
  logic [ADDR_W-1:0]     dump_addr;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use   <= CHANNELS_RST;
      units_per_channel <= UNITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CHANNELS: channels_in_use   <= cfg_data[CHAN_W-1:0];
        CFG_UNITS:    units_per_channel <= cfg_data[UNITS_W-1:0];
        default: ;
      endcase
    end
  end

  // command decode
  assign accept    = cmd_valid && !cmd_stall;
  assign ch_high   = cmd.channel > 8'(channels_in_use);
  assign unit_high = cmd.unit >= 4'(units_per_channel);
  assign bin_calc  = BIN_CALC_W'(cmd.channel - 8'd1) * BIN_CALC_W'(units_per_channel)
                   + BIN_CALC_W'(cmd.unit);
  assign bin_high  = 32'(bin_calc) >= 32'(MAX_BINS);

  always_comb begin
    if (cmd.channel == 8'd0) begin
      add_status = ST_CHAN_LOW;
    end else if (ch_high) begin
      add_status = ST_CHAN_HIGH;
    end else if (unit_high) begin
      add_status = ST_UNIT_HIGH;
    end else if (bin_high) begin
      add_status = ST_CHAN_HIGH;
    end else begin
      add_status = ST_OK;
    end
  end

  assign total_raw  = 8'(channels_in_use) * 8'(units_per_channel);
  assign total      = (32'(total_raw) > 32'(MAX_BINS)) ? CNT_W'(MAX_BINS) : CNT_W'(total_raw);
  assign room_short = 32'(cmd.room) < 32'(total);

  assign dump_addr  = idx[ADDR_W-1:0];
  assign dump_last  = (idx + CNT_W'(1)) == total;
  assign count_inc  = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
  assign count_dump = (op_byte && mem_rdata > BYTE_CAP) ? BYTE_CAP : mem_rdata;

  assign cmd_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (idx == LAST_BIN) begin
          state_next = clr_reply ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FUNC_ADD:   state_next = (add_status == ST_OK) ? S_ADD : S_RESP;
            FUNC_CLEAR: state_next = S_CLR;
            default: begin
              if (room_short) begin
                state_next = S_RESP;
              end else if (total != '0) begin
                state_next = S_DUMP;
              end
            end
          endcase
        end
      end
      S_ADD: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (res_ready && dump_last) begin
          state_next = S_IDLE;
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLR;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    idx_next       = idx;
    clr_reply_next = clr_reply;
    op_status_next = op_status;
    op_addr_next   = op_addr;
    op_byte_next   = op_byte;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    res_push       = 1'b0;
    res.status     = op_status;
    res.bin_index  = '0;
    res.count      = '0;
    res.last       = 1'b1;
    unique case (state)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = dump_addr;
        idx_next  = idx + CNT_W'(1);
      end
      S_IDLE: begin
        if (accept) begin
          case (cmd.func)
            FUNC_ADD: begin
              op_status_next = add_status;
              op_addr_next   = ADDR_W'(bin_calc);
              mem_re         = (add_status == ST_OK);
              mem_raddr      = ADDR_W'(bin_calc);
            end
            FUNC_CLEAR: begin
              op_status_next = ST_OK;
              clr_reply_next = 1'b1;
              idx_next       = '0;
            end
            default: begin
              op_status_next = room_short ? ST_ROOM : ST_OK;
              op_byte_next   = (cmd.func == FUNC_DUMP_BYTE);
              idx_next       = '0;
              mem_re         = !room_short && (total != '0);
            end
          endcase
        end
      end
      S_ADD: begin
        res.status    = ST_OK;
        res.bin_index = 6'(op_addr);
        res.count     = 32'(count_inc);
        if (res_ready) begin
          res_push  = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = op_addr;
          mem_wdata = count_inc;
        end
      end
      S_DUMP: begin
        res.status    = ST_OK;
        res.bin_index = 6'(dump_addr);
        res.count     = 32'(count_dump);
        res.last      = dump_last;
        if (res_ready) begin
          res_push  = 1'b1;
          mem_we    = 1'b1;
          mem_waddr = dump_addr;
          // fetch the following bin while this one is cleared
          if (!dump_last) begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(idx + CNT_W'(1));
            idx_next  = idx + CNT_W'(1);
          end
        end
      end
      S_RESP: begin
        res_push = res_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      idx       <= '0;
      clr_reply <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      clr_reply <= (state_next == S_CLR) ? clr_reply_next : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    op_status <= op_status_next;
    op_addr   <= op_addr_next;
    op_byte   <= op_byte_next;
  end

  `SBC_ASSERT_SAME(a_no_rw_same_bin, clk, rst, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same bin")
  `SBC_ASSERT_SAME(a_push_needs_room, clk, rst, res_push, res_ready, "result pushed into a full output register")
  `SBC_ASSERT_NEXT(a_dump_ends_idle, clk, rst, res_push && res.last && state == S_DUMP, state == S_IDLE, "dump did not return to idle after its final bin")
  `SBC_ASSERT_NEXT(a_accept_leaves_idle_on_work, clk, rst, accept && cmd.func == FUNC_CLEAR, state == S_CLR, "clear command did not start the sweep")

endmodule

### hw/rtl/spike_bin_counter.sv
// ---------------------------------------------------------------------------
// spike_bin_counter
// per-channel, per-unit spike event histogram with dump-and-clear readout
// ---------------------------------------------------------------------------
// Commands arrive on cmd (cmd_valid / cmd_stall); a transfer happens on an
// edge with cmd_valid high and cmd_stall low. Results leave on rsp
// (rsp_valid / rsp_stall) through an output register.
// An add event reads its bin from the count memory when it is accepted and
// writes it back when its result is pushed into the output register.
// Errors (bad channel, unit or short room) answer from the response state
// without a memory access. A dump reads one bin per cycle while the output
// register takes each result, and clears each bin as it goes; a bin's result
// is pushed into the output register once its read data is back.
// A clear-all command sweeps the memory one bin per cycle and then answers
// with one result. After reset the same sweep runs with cmd_stall high;
// configuration writes are taken at any time through cfg_we.
// When the receiver holds rsp_stall, the result stays in the output
// register and the sequencer waits without losing or repeating a bin.
// Only one command is in work at a time.
// ---------------------------------------------------------------------------
module spike_bin_counter import sbc_pkg::*; #(
  parameter int MAX_BINS   = MAX_BINS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  cmd_valid,
  output logic                  cmd_stall,
  input  cmd_t                  cmd,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp
);

  localparam int ADDR_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  logic                  mem_re;
  logic [ADDR_W-1:0]     mem_raddr;
  logic [COUNT_BITS-1:0] mem_rdata;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  res_ready;
  logic                  res_push;
  rsp_t                  res;

  sbc_mem #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  sbc_ctrl #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res)
  );

  sbc_rsp_reg u_rsp_reg (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res),
    .ready     (res_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### tb/spike_bin_counter_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// spike_bin_counter_test
// Self-checking bench for the spike bin counter. Commands go in with random
// gaps and results come out under random stalls. A histogram model kept here
// predicts every result, and each result transfer is compared field by field
// with the oldest prediction. Covers errors, clear, dumps, empty and
// oversized register settings and byte-mode dumps.
// ---------------------------------------------------------------------------
module spike_bin_counter_test;
  import sbc_pkg::*;

  localparam int NUM_BINS      = MAX_BINS_DEF;
  localparam int SETTLE_CYCLES = 100;  // longer than a full clear sweep
  localparam int PRINT_LIMIT   = 40;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  cmd_valid = 1'b0;
  logic                  cmd_stall;
  cmd_t                  cmd       = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned cmds_sent    = 0;
  int unsigned rsps_checked = 0;
  int unsigned cfg_writes   = 0;
  int unsigned mismatches   = 0;

  // histogram model and its register copies
  logic [31:0]        expected_bins [NUM_BINS];
  logic [CHAN_W-1:0]  model_channels = CHANNELS_RST;
  logic [UNITS_W-1:0] model_units    = UNITS_RST;
  rsp_t               pending_results [$];

  spike_bin_counter i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < snk_idle_pct);
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  function automatic int unsigned bins_in_use();
    int unsigned t;
    t = int'(model_channels) * int'(model_units);
    return (t > NUM_BINS) ? NUM_BINS : t;
  endfunction

  function automatic void push_result(input status_t st, input int unsigned bin,
                                      input logic [31:0] cnt, input logic lst);
    rsp_t r;
    r.status    = st;
    r.bin_index = 6'(bin);
    r.count     = cnt;
    r.last      = lst;
    pending_results.push_back(r);
  endfunction

  function automatic void update_histogram(input cmd_t c);
    int unsigned total;
    int unsigned bin;
    logic [31:0] cnt;
    total = bins_in_use();
    case (c.func)
      FUNC_ADD: begin
        if (c.channel == 0) begin
          push_result(ST_CHAN_LOW, 0, '0, 1'b1);
        end else if (c.channel > model_channels) begin
          push_result(ST_CHAN_HIGH, 0, '0, 1'b1);
        end else if (c.unit >= model_units) begin
          push_result(ST_UNIT_HIGH, 0, '0, 1'b1);
        end else begin
          bin = (int'(c.channel) - 1) * int'(model_units) + int'(c.unit);
          // oversized settings can point past the store
          if (bin >= NUM_BINS) begin
            push_result(ST_CHAN_HIGH, 0, '0, 1'b1);
          end else begin
            if (expected_bins[bin] != '1) expected_bins[bin]++;
            push_result(ST_OK, bin, expected_bins[bin], 1'b1);
          end
        end
      end
      FUNC_CLEAR: begin
        foreach (expected_bins[i]) expected_bins[i] = '0;
        push_result(ST_OK, 0, '0, 1'b1);
      end
      default: begin
        if (c.room < total) begin
          push_result(ST_ROOM, 0, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < total; i++) begin
            cnt = expected_bins[i];
            if (c.func == FUNC_DUMP_BYTE && cnt > BYTE_MAX) cnt = BYTE_MAX;
            push_result(ST_OK, i, cnt, (i + 1 == total));
            expected_bins[i] = '0;
          end
        end
      end
    endcase
  endfunction

  // valid stays high after a transfer until the next call decides otherwise
  task automatic send_cmd(input func_t f, input int unsigned ch, input int unsigned un,
                          input int unsigned rm);
    cmd_t c;
    c.func    = f;
    c.channel = 8'(ch);
    c.unit    = 4'(un);
    c.room    = 7'(rm);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    update_histogram(c);
    cmds_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    if (idx == CFG_CHANNELS) model_channels = CHAN_W'(val);
    else model_units = UNITS_W'(val);
    cfg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int unsigned chans, input int unsigned units);
    write_reg(CFG_CHANNELS, chans);
    write_reg(CFG_UNITS, units);
  endtask

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsps_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d bin %0d count %0d last %0d",
                                  rsp.status, rsp.bin_index, rsp.count, rsp.last));
      end else begin
        want = pending_results.pop_front();
        if (rsp.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
        if (rsp.bin_index !== want.bin_index)
          report_mismatch($sformatf("bin_index %0d, want %0d", rsp.bin_index,
                                    want.bin_index));
        if (rsp.count !== want.count)
          report_mismatch($sformatf("count %0d, want %0d (bin %0d)", rsp.count,
                                    want.count, want.bin_index));
        if (rsp.last !== want.last)
          report_mismatch($sformatf("last %0d, want %0d (bin %0d)", rsp.last, want.last,
                                    want.bin_index));
      end
    end
  end

  // reset register values: 16 channels of 4 units
  task automatic test_directed();
    send_cmd(FUNC_ADD, 1, 0, 0);
    send_cmd(FUNC_ADD, 1, 0, 0);
    send_cmd(FUNC_ADD, 16, 3, 127);
    send_cmd(FUNC_ADD, 0, 0, 0);
    send_cmd(FUNC_ADD, 0, 15, 0);      // channel check comes before unit check
    send_cmd(FUNC_ADD, 17, 0, 0);
    send_cmd(FUNC_ADD, 255, 15, 0);
    send_cmd(FUNC_ADD, 2, 4, 0);
    send_cmd(FUNC_ADD, 2, 15, 0);
    send_cmd(FUNC_DUMP, 0, 0, 63);     // one short of the bin count
    send_cmd(FUNC_DUMP_BYTE, 0, 0, 0);
    send_cmd(FUNC_DUMP, 0, 0, 64);
    send_cmd(FUNC_ADD, 8, 2, 0);
    send_cmd(FUNC_CLEAR, 255, 15, 127);
    send_cmd(FUNC_ADD, 8, 2, 0);
    send_cmd(FUNC_DUMP_BYTE, 0, 0, 127);
    send_cmd(FUNC_DUMP, 0, 0, 64);
  endtask

  task automatic test_config_extremes();
    wait_quiet();
    set_config(1, 1);
    send_cmd(FUNC_ADD, 1, 0, 0);
    send_cmd(FUNC_ADD, 2, 0, 0);
    send_cmd(FUNC_ADD, 1, 1, 0);
    send_cmd(FUNC_DUMP, 0, 0, 0);
    send_cmd(FUNC_DUMP_BYTE, 0, 0, 1);
    // no channels: empty store, dumps give nothing back
    wait_quiet();
    set_config(0, 4);
    send_cmd(FUNC_ADD, 1, 0, 0);
    send_cmd(FUNC_ADD, 0, 0, 0);
    send_cmd(FUNC_DUMP, 0, 0, 0);
    send_cmd(FUNC_DUMP_BYTE, 0, 0, 127);
    wait_quiet();
    set_config(16, 0);
    send_cmd(FUNC_ADD, 1, 0, 0);
    send_cmd(FUNC_ADD, 16, 15, 0);
    send_cmd(FUNC_DUMP, 0, 0, 0);
    // oversized settings: bin count capped at the store size
    wait_quiet();
    set_config(31, 7);
    send_cmd(FUNC_ADD, 10, 0, 0);
    send_cmd(FUNC_ADD, 10, 1, 0);
    send_cmd(FUNC_ADD, 31, 6, 0);
    send_cmd(FUNC_ADD, 32, 0, 0);
    send_cmd(FUNC_ADD, 1, 6, 0);
    send_cmd(FUNC_DUMP, 0, 0, 63);
    send_cmd(FUNC_DUMP, 0, 0, 64);
    wait_quiet();
    set_config(16, 4);
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned r;
    int unsigned total;
    int unsigned ch;
    int unsigned un;
    int unsigned rm;
    func_t       f;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 20 == 0) begin
        wait_quiet();
        r = $urandom_range(0, 9);
        if (r < 7) set_config($urandom_range(1, 16), $urandom_range(1, 4));
        else if (r < 9) set_config($urandom_range(0, 31), $urandom_range(0, 31));
        else set_config(16, 4);
      end
      total = bins_in_use();
      r  = $urandom_range(0, 99);
      ch = $urandom_range(0, 255);
      un = $urandom_range(0, 15);
      rm = $urandom_range(0, 127);
      if (r < 70) begin
        f = FUNC_ADD;
        if ($urandom_range(0, 99) < 85 && model_channels != 0 && model_units != 0) begin
          ch = $urandom_range(1, model_channels);
          un = $urandom_range(0, model_units - 1);
        end
      end else if (r < 76) begin
        f = FUNC_CLEAR;
      end else begin
        f = ($urandom_range(0, 1) != 0) ? FUNC_DUMP : FUNC_DUMP_BYTE;
        if ($urandom_range(0, 99) < 80) rm = $urandom_range(total, 127);
      end
      send_cmd(f, ch, un, rm);
    end
  endtask

  initial begin : main
    foreach (expected_bins[i]) expected_bins[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct = 23;
    snk_idle_pct = 61;
    test_directed();
    test_config_extremes();
    test_random(28);

    src_idle_pct = 61;
    snk_idle_pct = 23;
    test_random(28);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(28);

    wait_quiet();
    $display("covered %0d commands, %0d result transfers, %0d register writes",
             cmds_sent, rsps_checked, cfg_writes);
    $display("errors, clear, dumps, empty and oversized settings, byte-mode dumps; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout with %0d results still expected", pending_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
